### src/hvd_pkg.sv
`default_nettype none
package hvd_pkg;
    localparam int CordicStages = 32;
    localparam longint unsigned Pi60 = 64'd3622009729038561421;
    localparam longint unsigned PiDiv = 64'd900000000;
    localparam longint unsigned RadMul = Pi60 / PiDiv;
    localparam longint unsigned RadRem = Pi60 % PiDiv;
    // RadRem / PiDiv as a 32-bit fraction, rounded down
    localparam longint unsigned RecF = (RadRem << 32) / PiDiv;
    localparam longint QuarterH = 64'sd1800000000;
    localparam longint TurnH = 64'sd7200000000;
    localparam longint LatMax = 64'sd900000000;
    localparam longint LonMax = 64'sd1800000000;
    localparam longint unsigned DistMax = 64'd2001508700;
    localparam longint unsigned TwoRcm = 64'd1274200000;

    // atan(2^-i) in q62 radians
    function automatic logic signed [63:0] atan_q62(input int i);
        logic signed [63:0] acc;
        logic [63:0] t;
        int k;
        logic neg;
        acc = '0;
        neg = 1'b0;
        if (i == 0) begin
            acc = 64'(Pi60);
        end else begin
            for (k = 1; k * i <= 62; k += 2) begin
                t = ((64'd1 << (62 - k * i)) + 64'(k / 2)) / 64'(k);
                if (neg) acc = acc - $signed(t);
                else acc = acc + $signed(t);
                neg = !neg;
            end
        end
        return acc;
    endfunction

    typedef struct packed {
        logic signed [31:0] sn;
        logic signed [31:0] cs;
    } t_sc;
endpackage
`default_nettype wire

### src/hvd_sincos.sv
`default_nettype none
// pipelined rotation cordic, sin/cos of a half angle in 5e-8 degree units
// four stages turn the angle into q62 radians ahead of the cordic stages
module hvd_sincos (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [35:0] i_h,
    output hvd_pkg::t_sc            o_sc
);
    localparam int N = hvd_pkg::CordicStages;
    localparam logic signed [35:0] QtrH  = 36'(hvd_pkg::QuarterH);
    localparam logic signed [35:0] HalfQ = 36'(hvd_pkg::QuarterH / 2);
    localparam logic signed [35:0] Q3h   = 36'(3 * hvd_pkg::QuarterH / 2);
    logic signed [63:0] r_x [N+1];
    logic signed [63:0] r_y [N+1];
    logic signed [63:0] r_z [N+1];
    logic [1:0]         r_q [N+2];
    logic signed [31:0] r_c, r_s;

    logic [29:0] r_a_mag;
    logic        r_a_neg, r_b_neg, r_c_neg, r_d_neg;
    logic [1:0]  r_a_q, r_b_q, r_c_q, r_d_q;
    logic [63:0] r_b_base, r_b_num;
    logic [29:0] r_b_est;
    logic [63:0] r_c_sum, r_c_num, r_c_prod;
    logic [63:0] r_d_rad;

    logic [2:0]         up;
    logic signed [35:0] rr;
    logic [63:0]        rem;

    // quadrant reduction by compare and subtract
    always_comb begin
        up = 3'(i_h >= -Q3h) + 3'(i_h >= -HalfQ) + 3'(i_h >= HalfQ) + 3'(i_h >= Q3h);
        case (up)
            3'd0:    rr = i_h + QtrH + QtrH;
            3'd1:    rr = i_h + QtrH;
            3'd2:    rr = i_h;
            3'd3:    rr = i_h - QtrH;
            default: rr = i_h - QtrH - QtrH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mag <= rr[35] ? 30'(-rr) : 30'(rr);
            r_a_neg <= rr[35];
            r_a_q   <= 2'(up) + 2'd2;
        end
    end

    // radians: whole part, remainder numerator and reciprocal quotient estimate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_base <= 64'(r_a_mag) * hvd_pkg::RadMul;
            r_b_num  <= 64'(r_a_mag) * hvd_pkg::RadRem + hvd_pkg::PiDiv / 2;
            r_b_est  <= 30'((64'(r_a_mag) * hvd_pkg::RecF + (64'd1 << 31)) >> 32);
            r_b_neg  <= r_a_neg;
            r_b_q    <= r_a_q;
        end
    end

    // estimate is exact or one low; form the check product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_sum  <= r_b_base + 64'(r_b_est);
            r_c_num  <= r_b_num;
            r_c_prod <= 64'(r_b_est) * hvd_pkg::PiDiv;
            r_c_neg  <= r_b_neg;
            r_c_q    <= r_b_q;
        end
    end

    // correct the quotient by one where the remainder is too large
    always_comb begin
        rem = r_c_num - r_c_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_rad <= r_c_sum + 64'(rem >= hvd_pkg::PiDiv);
            r_d_neg <= r_c_neg;
            r_d_q   <= r_c_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= 64'sd1 <<< 60;
            r_y[0] <= '0;
            r_z[0] <= r_d_neg ? -$signed(r_d_rad) : $signed(r_d_rad);
            r_q[0] <= r_d_q;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < N; i++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[i+1] <= r_q[i];
                if (!r_z[i][63]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - hvd_pkg::atan_q62(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + hvd_pkg::atan_q62(i);
                end
            end
        end
    end

    // round to q30 and map quadrant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c <= 32'((r_x[N] + (64'sd1 <<< 29)) >>> 30);
            r_s <= 32'((r_y[N] + (64'sd1 <<< 29)) >>> 30);
            r_q[N+1] <= r_q[N];
        end
    end

    always_comb begin
        case (r_q[N+1])
            2'd0:    begin o_sc.cs = r_c;  o_sc.sn = r_s;  end
            2'd1:    begin o_sc.cs = -r_s; o_sc.sn = r_c;  end
            2'd2:    begin o_sc.cs = -r_c; o_sc.sn = -r_s; end
            default: begin o_sc.cs = r_s;  o_sc.sn = -r_c; end
        endcase
    end
endmodule
`default_nettype wire

### src/hvd_vector.sv
`default_nettype none
// pipelined vectoring cordic, gives scaled norm and angle in q62
module hvd_vector (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [63:0] i_x,
    input  wire logic signed [63:0] i_y,
    output      logic signed [63:0] o_x,
    output      logic signed [63:0] o_z
);
    localparam int N = hvd_pkg::CordicStages;
    logic signed [63:0] r_x [N+1];
    logic signed [63:0] r_y [N+1];
    logic signed [63:0] r_z [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_st
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + hvd_pkg::atan_q62(i);
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - hvd_pkg::atan_q62(i);
                end
            end
        end
    end

    assign o_x = r_x[N];
    assign o_z = r_z[N];
endmodule
`default_nettype wire

### src/haversine_distance.sv
`default_nettype none
// channel | dir | payload
// s_axis  | in  | tdata: lat_a[30:0], lon_a[62:31], lat_b[93:63], lon_b[125:94]
// m_axis  | out | tdata: distance_cm[30:0]; tuser: input_clamped
// one request accepted per cycle unless the output stalls; latency is set by
// the angle conversion and the three cordic pipelines in series (sin/cos, two
// norms, atan2)
// the whole pipeline advances only when the output register is free or taken
// reset clears valid bits only; payload registers are not reset
module haversine_distance (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // lat_a, lon_a, lat_b, lon_b
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output      logic [31:0]  m_axis_tdata,  // distance_cm
    output      logic         m_axis_tuser   // input_clamped
);
    localparam int N = hvd_pkg::CordicStages;
    localparam int Lat = 2 * N + 12;
    localparam int Dep = Lat + N + 1;

    logic en;
    logic [Dep-1:0] r_v;
    logic [Dep-1:0] r_f;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic signed [30:0] lat_a, lat_b;
    logic signed [31:0] lon_a, lon_b;
    assign lat_a = s_axis_tdata[30:0];
    assign lon_a = s_axis_tdata[62:31];
    assign lat_b = s_axis_tdata[93:63];
    assign lon_b = s_axis_tdata[125:94];

    logic signed [35:0] la, lb, oa, ob, n_hd, n_hl, n_hm;
    logic n_flag;
    logic signed [35:0] r_hd, r_hl, r_hm;

    // clamp
    always_comb begin
        n_flag = 1'b0;
        la = 36'(lat_a); lb = 36'(lat_b); oa = 36'(lon_a); ob = 36'(lon_b);
        if (la > 36'(hvd_pkg::LatMax)) begin la = 36'(hvd_pkg::LatMax); n_flag = 1'b1; end
        if (la < -36'(hvd_pkg::LatMax)) begin la = -36'(hvd_pkg::LatMax); n_flag = 1'b1; end
        if (lb > 36'(hvd_pkg::LatMax)) begin lb = 36'(hvd_pkg::LatMax); n_flag = 1'b1; end
        if (lb < -36'(hvd_pkg::LatMax)) begin lb = -36'(hvd_pkg::LatMax); n_flag = 1'b1; end
        if (oa > 36'(hvd_pkg::LonMax)) begin oa = 36'(hvd_pkg::LonMax); n_flag = 1'b1; end
        if (oa < -36'(hvd_pkg::LonMax)) begin oa = -36'(hvd_pkg::LonMax); n_flag = 1'b1; end
        if (ob > 36'(hvd_pkg::LonMax)) begin ob = 36'(hvd_pkg::LonMax); n_flag = 1'b1; end
        if (ob < -36'(hvd_pkg::LonMax)) begin ob = -36'(hvd_pkg::LonMax); n_flag = 1'b1; end
        n_hd = lb - la;
        n_hl = ob - oa;
        n_hm = la + lb;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hd <= n_hd; r_hl <= n_hl; r_hm <= n_hm;
        end
    end

    // valid and flag shift line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[Dep-2:0], s_axis_tvalid};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) r_f <= {r_f[Dep-2:0], n_flag};
    end

    hvd_pkg::t_sc sd, sl, sm;
    hvd_sincos u_sd (.i_clk(i_clk), .i_en(en), .i_h(r_hd), .o_sc(sd));
    hvd_sincos u_sl (.i_clk(i_clk), .i_en(en), .i_h(r_hl), .o_sc(sl));
    hvd_sincos u_sm (.i_clk(i_clk), .i_en(en), .i_h(r_hm), .o_sc(sm));

    // products to q58 magnitudes
    logic signed [63:0] r_pr, r_ps, r_pp, r_pq, r_ar, r_as, r_ap, r_aq;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pr <= (64'(sd.sn) * 64'(sl.cs)) >>> 2;
            r_ps <= (64'(sm.cs) * 64'(sl.sn)) >>> 2;
            r_pp <= (64'(sd.cs) * 64'(sl.cs)) >>> 2;
            r_pq <= (64'(sm.sn) * 64'(sl.sn)) >>> 2;
            r_ar <= r_pr[63] ? -r_pr : r_pr;
            r_as <= r_ps[63] ? -r_ps : r_ps;
            r_ap <= r_pp[63] ? -r_pp : r_pp;
            r_aq <= r_pq[63] ? -r_pq : r_pq;
        end
    end

    logic signed [63:0] ys, xs, z0, z1, z, xc;
    hvd_vector u_va (.i_clk(i_clk), .i_en(en), .i_x(r_ar), .i_y(r_as), .o_x(ys), .o_z(z0));
    hvd_vector u_vb (.i_clk(i_clk), .i_en(en), .i_x(r_ap), .i_y(r_aq), .o_x(xs), .o_z(z1));
    hvd_vector u_vc (.i_clk(i_clk), .i_en(en), .i_x(xs), .i_y(ys), .o_x(xc), .o_z(z));

    // scale to centimetres
    logic [33:0] r_z32;
    logic [63:0] r_d;
    logic [30:0] r_out;
    logic r_ov, r_of;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z32 <= z[63] ? '0 : 34'((64'(z) + (64'd1 << 29)) >> 30);
            r_d   <= (64'(r_z32) * hvd_pkg::TwoRcm + (64'd1 << 31)) >> 32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v[Dep-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= (r_d > hvd_pkg::DistMax) ? 31'(hvd_pkg::DistMax) : r_d[30:0];
            r_of  <= r_f[Dep-1];
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_out};
    assign m_axis_tuser  = r_of;

    logic unused;
    assign unused = ^{z0, z1, xc, s_axis_tdata[127:126], sd.sn[0]};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");
    a_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata <= 32'(hvd_pkg::DistMax))
        else $error("distance above maximum");
endmodule
`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
    localparam int LatencyCycles = 3 * hvd_pkg::CordicStages + 13;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;   // lat_a, lon_a, lat_b, lon_b
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [31:0]  m_axis_tdata;   // distance_cm
    logic         m_axis_tuser;   // input_clamped

    bit idle_on;
    bit hold_req;

    // expected distance and clamp flag per accepted request
    typedef struct {
        logic [30:0] dist_cm;
        logic        clamped;
    } t_dist_exp;

    class distance_scoreboard;
        t_dist_exp pending[$];
        int        errors;

        // atan(2^-i) in q62 radians by the odd power series
        function longint arctan_q62(int i);
            longint acc;
            longint unsigned t;
            int k;
            bit neg;
            acc = 0;
            neg = 0;
            if (i == 0) return longint'(hvd_pkg::Pi60);
            for (k = 1; k * i <= 62; k += 2) begin
                t = ((64'd1 << (62 - k * i)) + longint'(k / 2)) / longint'(k);
                if (neg) acc -= longint'(t);
                else acc += longint'(t);
                neg = !neg;
            end
            return acc;
        endfunction

        // gain-scaled sin and cos in q30 of an angle in 5e-8 degree units
        function void rot_sincos(longint h, output longint sn, output longint cs);
            longint hp, qd, r, z, x, y, dx, dy, a, c, s;
            longint unsigned mag, rad;
            hp = h + hvd_pkg::TurnH;
            qd = (hp + hvd_pkg::QuarterH / 2) / hvd_pkg::QuarterH;
            r = hp - qd * hvd_pkg::QuarterH;
            mag = (r < 0) ? longint'(-r) : longint'(r);
            rad = mag * hvd_pkg::RadMul
                + (mag * hvd_pkg::RadRem + hvd_pkg::PiDiv / 2) / hvd_pkg::PiDiv;
            z = (r < 0) ? -longint'(rad) : longint'(rad);
            x = 64'sd1 <<< 60;
            y = 0;
            for (int i = 0; i < hvd_pkg::CordicStages; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                a = arctan_q62(i);
                if (z >= 0) begin
                    x -= dx; y += dy; z -= a;
                end else begin
                    x += dx; y -= dy; z += a;
                end
            end
            c = (x + (64'sd1 <<< 29)) >>> 30;
            s = (y + (64'sd1 <<< 29)) >>> 30;
            case (qd & 3)
                0: begin cs = c;  sn = s;  end
                1: begin cs = -s; sn = c;  end
                2: begin cs = -c; sn = -s; end
                default: begin cs = s; sn = -c; end
            endcase
        endfunction

        // vectoring pass: returns scaled norm, angle in q62
        function longint vec_norm(longint x, longint y, output longint ang);
            longint z, dx, dy, a;
            z = 0;
            for (int i = 0; i < hvd_pkg::CordicStages; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                a = arctan_q62(i);
                if (y > 0) begin
                    x += dx; y -= dy; z += a;
                end else begin
                    x -= dx; y += dy; z -= a;
                end
            end
            ang = z;
            return x;
        endfunction

        function longint clip(longint v, longint lim, inout bit flag);
            if (v > lim) begin flag = 1; return lim; end
            if (v < -lim) begin flag = 1; return -lim; end
            return v;
        endfunction

        function longint absv(longint v);
            return (v < 0) ? -v : v;
        endfunction

        function void note_request(logic [127:0] d);
            longint la, oa, lb, ob, sd, cd, sl, cl, sm, cm, p, q, r, s;
            longint xs, ys, z, unused;
            longint unsigned z32, d_cm;
            bit flag;
            t_dist_exp e;
            flag = 0;
            la = longint'($signed(d[30:0]));
            oa = longint'($signed(d[62:31]));
            lb = longint'($signed(d[93:63]));
            ob = longint'($signed(d[125:94]));
            la = clip(la, hvd_pkg::LatMax, flag);
            lb = clip(lb, hvd_pkg::LatMax, flag);
            oa = clip(oa, hvd_pkg::LonMax, flag);
            ob = clip(ob, hvd_pkg::LonMax, flag);
            rot_sincos(lb - la, sd, cd);
            rot_sincos(ob - oa, sl, cl);
            rot_sincos(la + lb, sm, cm);
            r = absv((sd * cl) >>> 2);
            s = absv((cm * sl) >>> 2);
            p = absv((cd * cl) >>> 2);
            q = absv((sm * sl) >>> 2);
            ys = vec_norm(r, s, unused);
            xs = vec_norm(p, q, unused);
            void'(vec_norm(xs, ys, z));
            if (z < 0) z = 0;
            z32 = (longint'(z) + (64'd1 << 29)) >> 30;
            d_cm = (z32 * hvd_pkg::TwoRcm + (64'd1 << 31)) >> 32;
            if (d_cm > hvd_pkg::DistMax) d_cm = hvd_pkg::DistMax;
            e.dist_cm = d_cm[30:0];
            e.clamped = flag;
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(logic [31:0] data, logic clamped);
            t_dist_exp e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: unexpected result dist=%0d clamped=%0b", $time, data, clamped);
                return;
            end
            e = pending.pop_front();
            if (data !== {1'b0, e.dist_cm}) begin
                errors++;
                $display("%0t: distance_cm expected %0d actual %0d", $time, e.dist_cm, data);
            end
            if (clamped !== e.clamped) begin
                errors++;
                $display("%0t: input_clamped expected %0b actual %0b",
                         $time, e.clamped, clamped);
            end
        endfunction
    endclass

    distance_scoreboard sb = new();

    haversine_distance u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // watch both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // result side back-pressure
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (600) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [127:0] pack_points(longint la, longint oa, longint lb, longint ob);
        return {2'b00, ob[31:0], lb[30:0], oa[31:0], la[30:0]};
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_request(logic [127:0] d);
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    function automatic longint rnd_lat();
        return longint'($urandom_range(0, 1800000000)) - 64'sd900000000;
    endfunction

    function automatic longint rnd_lon();
        return longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
    endfunction

    // mostly valid points, some close pairs, some raw bit noise
    task automatic send_random();
        longint la, oa;
        int pick;
        pick = $urandom_range(0, 19);
        la = rnd_lat();
        oa = rnd_lon();
        if (pick < 14)
            send_request(pack_points(la, oa, rnd_lat(), rnd_lon()));
        else if (pick < 17)
            send_request(pack_points(la, oa, la + $urandom_range(0, 2000) - 1000,
                                     oa + $urandom_range(0, 2000) - 1000));
        else
            send_request({$urandom, $urandom, $urandom, $urandom} & {2'b00, {126{1'b1}}});
    endtask

    initial begin
        int wait_cnt;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        idle_on = 1;
        hold_req = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_request(pack_points(0, 0, 0, 0));
        send_request(pack_points(0, 0, 0, 1800000000));
        send_request(pack_points(900000000, 0, -900000000, 0));
        send_request(pack_points(900000000, 123, 900000000, -1700000000));
        send_request(pack_points(0, -1800000000, 0, 1800000000));
        send_request(pack_points(0, 1700000000, 0, -1700000000));
        send_request(pack_points(1, 0, 0, 0));
        send_request(pack_points(0, 0, 0, 1));
        send_request(pack_points(1, 0, -1, 1799999999));
        send_request(pack_points(450000000, 900000000, -450000000, -900000000));
        send_request(pack_points(-900000000, -1800000000, 900000000, 1800000000));
        // clamped corners (widest codes, values just past the limits), then a close pair
        send_request(pack_points(-1073741824, 0, 0, 0));
        send_request(pack_points(0, 0, 1073741823, 0));
        send_request(pack_points(0, -2147483648, 0, 0));
        send_request(pack_points(0, 0, 0, 2147483647));
        send_request(pack_points(900000001, 1800000001, -900000001, -1800000001));
        send_request(pack_points(-1073741824, -2147483648, 1073741823, 2147483647));
        send_request(pack_points(123456789, -98765432, 123456790, -98765431));

        repeat (300) send_random();

        // long result stall while requests keep coming
        hold_req = 1;
        repeat (150) send_random();

        // drain completely before going on
        s_axis_tvalid <= 1'b0;
        wait_cnt = 0;
        do begin
            @(posedge i_clk);
            wait_cnt++;
        end while (sb.pending.size() != 0 && wait_cnt < 20000);
        repeat (50) send_random();

        // full rate to the end
        idle_on = 0;
        repeat (100) send_random();
        s_axis_tvalid <= 1'b0;

        wait_cnt = 0;
        while (sb.pending.size() != 0 && wait_cnt < 50000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (LatencyCycles + 20) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending.size());
        end
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end
endmodule

### sim.f
src/hvd_pkg.sv
src/hvd_sincos.sv
src/hvd_vector.sv
src/haversine_distance.sv
tb/sv/tb.sv
